### sv/contiguous_block_allocator_defines.svh
// Assertion macros for the contiguous block allocator.
// No dependencies; included by the modules that carry assertions.
`ifndef CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH
`define CONTIGUOUS_BLOCK_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// Condition that holds at every clock edge outside reset
`define CBA_ASSERT_ALWAYS(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// Same-cycle implication
`define CBA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define CBA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CBA_ASSERT_ALWAYS(lbl, cond, msg)
`define CBA_ASSERT_IMP(lbl, ante, cons, msg)
`define CBA_ASSERT_NXT(lbl, ante, cons, msg)

`endif

`endif

### sv/cba_pkg.sv
// Shared constants of the contiguous block allocator: result status codes,
// request command codes and field widths. No dependencies.
package cba_pkg;

    // Field widths
    localparam int BLOCK_W  = 6;
    localparam int LENGTH_W = 7;
    localparam int STATUS_W = 3;

    // Results one allocation may produce, and the counter that tracks them
    localparam int MAX_RESULTS = 64;
    localparam int RES_CNT_W   = $clog2(MAX_RESULTS);
    localparam logic [RES_CNT_W-1:0] RES_CNT_LAST = RES_CNT_W'(MAX_RESULTS - 1);

    // Request commands
    localparam logic CMD_MARK  = 1'b0;
    localparam logic CMD_ALLOC = 1'b1;

    // Result status codes
    localparam logic [STATUS_W-1:0] ST_ALLOC  = 3'd0;
    localparam logic [STATUS_W-1:0] ST_SKIP   = 3'd1;
    localparam logic [STATUS_W-1:0] ST_REJECT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_MARKED = 3'd3;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 3'd4;

endpackage

### sv/contiguous_block_allocator.sv
// Contiguous block allocator: busy bitmap in a one-bit synchronous memory
// with a read-modify-write walk. Uses cba_pkg and the assertion macro header.
//
// Usage:
//   Request channel (in_valid/in_ready, cmd, start_block, length): cmd mark
//   sets one block busy; cmd allocate claims length free blocks walking up
//   from start_block. Result channel (out_valid/out_ready, block_index,
//   status, out_of_space, last) returns one or more results per request;
//   last flags the final one.
//   Flow: a mark or a reject answer goes through S_REPLY, which loads the
//   result register once it is free. An allocation reads its start block in
//   the accept cycle and then emits one result per cycle while the result
//   register is free, one bitmap entry each, up to 64 entries. The bitmap
//   memory has one read and one write port, and the single walk pointer sets
//   this rate. One request is in work at a time; in_ready is high only
//   between requests.
//   Reset: the bitmap is cleared by a pass over its min(NUM_BLOCKS, 128)
//   entries, one entry per cycle, during which no request is accepted.
//   Stalls: a held result keeps the walk parked on its entry; the walk
//   resumes as soon as the result register empties.
`include "contiguous_block_allocator_defines.svh"

module contiguous_block_allocator #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic                                cmd,
    input  logic [cba_pkg::BLOCK_W-1:0]         start_block,
    input  logic [cba_pkg::LENGTH_W-1:0]        length,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic [cba_pkg::BLOCK_W-1:0]         block_index,
    output logic [cba_pkg::STATUS_W-1:0]        status,
    output logic                                out_of_space,
    output logic                                last
);

    // A walk starts below 64 and emits at most 64 results, so it never
    // touches an entry above 126.
    localparam int MEM_DEPTH = (NUM_BLOCKS < 128) ? NUM_BLOCKS : 128;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(MEM_DEPTH - 1);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_REPLY,
        S_WALK
    } state_t;

    state_t                              state_reg, state_next;
    logic [ADDR_W-1:0]                   addr_reg, addr_next;
    logic [cba_pkg::BLOCK_W-1:0]         start_reg, start_next;
    logic [cba_pkg::LENGTH_W-1:0]        length_reg, length_next;
    logic [cba_pkg::LENGTH_W-1:0]        claimed_reg, claimed_next;
    logic [cba_pkg::RES_CNT_W-1:0]       count_reg, count_next;
    logic                                first_reg, first_next;
    logic [cba_pkg::STATUS_W-1:0]        reply_reg, reply_next;
    logic                                out_valid_reg, out_valid_next;
    logic [cba_pkg::BLOCK_W-1:0]         out_index_reg, out_index_next;
    logic [cba_pkg::STATUS_W-1:0]        out_status_reg, out_status_next;
    logic                                out_oos_reg, out_oos_next;
    logic                                out_last_reg, out_last_next;

    // Bitmap memory and its ports
    logic                                busy_mem [MEM_DEPTH];
    logic                                rd_data_reg;
    logic                                mem_re;
    logic [ADDR_W-1:0]                   mem_ra;
    logic                                mem_we;
    logic [ADDR_W-1:0]                   mem_wa;
    logic                                mem_wd;

    // Walk decode
    logic                                accept;
    logic                                start_ok;
    logic                                slot_free;
    logic                                emit;
    logic                                first_reject;
    logic                                first_empty;
    logic                                special;
    logic                                claim;
    logic [cba_pkg::LENGTH_W-1:0]        claimed_after;
    logic                                walk_done;

    assign in_ready     = (state_reg == S_IDLE);
    assign accept       = in_valid && in_ready;
    assign start_ok     = (32'(start_block) < NUM_BLOCKS);
    assign slot_free    = !out_valid_reg || out_ready;
    assign emit         = (state_reg == S_WALK) && slot_free;

    assign out_valid    = out_valid_reg;
    assign block_index  = out_index_reg;
    assign status       = out_status_reg;
    assign out_of_space = out_oos_reg;
    assign last         = out_last_reg;

    // Classify the entry the walk is on
    always_comb
    begin
        first_reject  = first_reg && rd_data_reg;
        first_empty   = first_reg && !rd_data_reg && (length_reg == '0);
        special       = first_reject || first_empty;
        claim         = !special && !rd_data_reg;
        claimed_after = claimed_reg + cba_pkg::LENGTH_W'(claim);
        walk_done     = special
                        || (claimed_after == length_reg)
                        || (addr_reg == LAST_ADDR)
                        || (count_reg == cba_pkg::RES_CNT_LAST);
    end

    // Memory port control
    always_comb
    begin
        mem_re = 1'b0;
        mem_ra = addr_reg + ADDR_W'(1);
        mem_we = 1'b0;
        mem_wa = addr_reg;
        mem_wd = 1'b1;
        unique case (state_reg)
            S_CLEAR:
            begin
                mem_we = 1'b1;
                mem_wd = 1'b0;
            end
            S_IDLE:
            begin
                mem_ra = ADDR_W'(start_block);
                mem_wa = ADDR_W'(start_block);
                mem_re = accept && start_ok && (cmd == cba_pkg::CMD_ALLOC);
                mem_we = accept && start_ok && (cmd == cba_pkg::CMD_MARK);
            end
            S_WALK:
            begin
                mem_re = emit && !walk_done;
                mem_we = emit && claim;
            end
            default:
            begin
            end
        endcase
    end

    // Next state and result register
    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        start_next      = start_reg;
        length_next     = length_reg;
        claimed_next    = claimed_reg;
        count_next      = count_reg;
        first_next      = first_reg;
        reply_next      = reply_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_index_next  = out_index_reg;
        out_status_next = out_status_reg;
        out_oos_next    = out_oos_reg;
        out_last_next   = out_last_reg;

        unique case (state_reg)
            S_CLEAR:
            begin
                // Sweep the bitmap to all free
                addr_next = addr_reg + ADDR_W'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    addr_next  = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    start_next   = start_block;
                    length_next  = length;
                    addr_next    = ADDR_W'(start_block);
                    claimed_next = '0;
                    count_next   = '0;
                    first_next   = 1'b1;
                    priority if (!start_ok)
                    begin
                        reply_next = cba_pkg::ST_REJECT;
                        state_next = S_REPLY;
                    end
                    else if (cmd == cba_pkg::CMD_MARK)
                    begin
                        reply_next = cba_pkg::ST_MARKED;
                        state_next = S_REPLY;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_REPLY:
            begin
                // Hold until the result register frees up
                if (slot_free)
                begin
                    out_valid_next  = 1'b1;
                    out_index_next  = start_reg;
                    out_status_next = reply_reg;
                    out_oos_next    = 1'b0;
                    out_last_next   = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            S_WALK:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = cba_pkg::BLOCK_W'(addr_reg);
                    priority if (first_reject)
                        out_status_next = cba_pkg::ST_REJECT;
                    else if (first_empty)
                        out_status_next = cba_pkg::ST_EMPTY;
                    else if (claim)
                        out_status_next = cba_pkg::ST_ALLOC;
                    else
                        out_status_next = cba_pkg::ST_SKIP;
                    out_oos_next  = !special && walk_done && (claimed_after != length_reg);
                    out_last_next = walk_done;
                    claimed_next  = claimed_after;
                    first_next    = 1'b0;
                    // Advance to the next entry or finish
                    if (walk_done)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        addr_next  = addr_reg + ADDR_W'(1);
                        count_next = count_reg + cba_pkg::RES_CNT_W'(1);
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            addr_reg      <= '0;
            out_valid_reg <= 1'b0;
            first_reg     <= 1'b0;
            claimed_reg   <= '0;
            count_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            addr_reg      <= addr_next;
            out_valid_reg <= out_valid_next;
            first_reg     <= first_next;
            claimed_reg   <= claimed_next;
            count_reg     <= count_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        start_reg      <= start_next;
        length_reg     <= length_next;
        reply_reg      <= reply_next;
        out_index_reg  <= out_index_next;
        out_status_reg <= out_status_next;
        out_oos_reg    <= out_oos_next;
        out_last_reg   <= out_last_next;
    end

    // Bitmap memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            busy_mem[mem_wa] <= mem_wd;
        end
        if (mem_re)
        begin
            rd_data_reg <= busy_mem[mem_ra];
        end
    end

    // Checks
    `CBA_ASSERT_IMP(a_single_result_clean,
        out_valid && (status == cba_pkg::ST_REJECT || status == cba_pkg::ST_MARKED
                      || status == cba_pkg::ST_EMPTY),
        last && !out_of_space,
        "single-result answer must be last without out_of_space")
    `CBA_ASSERT_IMP(a_oos_on_last, out_valid && out_of_space,
        last && (status == cba_pkg::ST_ALLOC || status == cba_pkg::ST_SKIP),
        "out_of_space only on the last result of a walk")
    `CBA_ASSERT_IMP(a_claim_below_length, (state_reg == S_WALK) && !first_reg,
        claimed_reg < length_reg, "walk continued after claiming all blocks")
    `CBA_ASSERT_NXT(a_walk_steps_by_one, emit && !walk_done,
        (state_reg == S_WALK) && (addr_reg == $past(addr_reg) + ADDR_W'(1)),
        "walk pointer did not advance by one")
    `CBA_ASSERT_IMP(a_write_free_only, (state_reg == S_WALK) && mem_we,
        !rd_data_reg && !special, "walk wrote over a busy entry")

endmodule
